@@ src/xonly_ladder_scalar_mul_assert.svh @@
// Assertion macros shared by the checker of the ladder block.
`ifndef XONLY_LADDER_SCALAR_MUL_ASSERT_SVH
`define XONLY_LADDER_SCALAR_MUL_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define XLSM_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define XLSM_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/xlsm_pkg.sv @@
`default_nettype none

package xlsm_pkg;

  localparam int REG_AW = 5;

  // Actions of the input word.
  localparam logic [2:0] ACT_LOAD_A = 3'd0;
  localparam logic [2:0] ACT_LOAD_B = 3'd1;
  localparam logic [2:0] ACT_LOAD_P = 3'd2;
  localparam logic [2:0] ACT_LOAD_X = 3'd3;
  localparam logic [2:0] ACT_LOAD_Z = 3'd4;
  localparam logic [2:0] ACT_LOAD_K = 3'd5;
  localparam logic [2:0] ACT_START  = 3'd6;

  // Field operations of the sequencer.
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;
  localparam logic [1:0] OP_RED = 2'd3;

  // Register file slots, each one field element stored limb by limb.
  localparam logic [REG_AW-1:0] RG_A_RAW = 5'd0;
  localparam logic [REG_AW-1:0] RG_B_RAW = 5'd1;
  localparam logic [REG_AW-1:0] RG_X_RAW = 5'd2;
  localparam logic [REG_AW-1:0] RG_Z_RAW = 5'd3;
  localparam logic [REG_AW-1:0] RG_CA    = 5'd4;
  localparam logic [REG_AW-1:0] RG_CB    = 5'd5;
  localparam logic [REG_AW-1:0] RG_PX    = 5'd6;
  localparam logic [REG_AW-1:0] RG_PZ    = 5'd7;
  localparam logic [REG_AW-1:0] RG_R0X   = 5'd8;
  localparam logic [REG_AW-1:0] RG_R0Z   = 5'd9;
  localparam logic [REG_AW-1:0] RG_R1X   = 5'd10;
  localparam logic [REG_AW-1:0] RG_R1Z   = 5'd11;
  localparam logic [REG_AW-1:0] RG_S0    = 5'd12;
  localparam logic [REG_AW-1:0] RG_S1    = 5'd13;
  localparam logic [REG_AW-1:0] RG_S2    = 5'd14;
  localparam logic [REG_AW-1:0] RG_S3    = 5'd15;
  localparam logic [REG_AW-1:0] RG_S4    = 5'd16;
  localparam logic [REG_AW-1:0] RG_S5    = 5'd17;
  localparam logic [REG_AW-1:0] RG_S6    = 5'd18;
  localparam logic [REG_AW-1:0] RG_S7    = 5'd19;
  localparam logic [REG_AW-1:0] RG_S8    = 5'd20;
  // Slots that follow the current scalar bit: the sum target and the doubled point.
  localparam logic [REG_AW-1:0] RG_VAX   = 5'd28;
  localparam logic [REG_AW-1:0] RG_VAZ   = 5'd29;
  localparam logic [REG_AW-1:0] RG_VDX   = 5'd30;
  localparam logic [REG_AW-1:0] RG_VDZ   = 5'd31;

  localparam logic [5:0] PC_INIT_END  = 6'd7;
  localparam logic [5:0] PC_ADD_START = 6'd8;
  localparam logic [5:0] PC_DBL_START = 6'd25;
  localparam logic [5:0] PC_DBL_END   = 6'd42;

  typedef struct packed {
    logic [1:0]        op;
    logic [REG_AW-1:0] dst;
    logic [REG_AW-1:0] sa;
    logic [REG_AW-1:0] sb;
  } uop_t;

  function automatic uop_t mk(input logic [1:0] op, input logic [REG_AW-1:0] d,
                              input logic [REG_AW-1:0] a, input logic [REG_AW-1:0] b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    return u;
  endfunction

  // Program: reduce operands, differential add, then doubling.
  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_RED, RG_CA,  RG_A_RAW, RG_A_RAW);
      6'd1:  u = mk(OP_RED, RG_CB,  RG_B_RAW, RG_B_RAW);
      6'd2:  u = mk(OP_RED, RG_PX,  RG_X_RAW, RG_X_RAW);
      6'd3:  u = mk(OP_RED, RG_PZ,  RG_Z_RAW, RG_Z_RAW);
      6'd4:  u = mk(OP_RED, RG_R0X, RG_X_RAW, RG_X_RAW);
      6'd5:  u = mk(OP_RED, RG_R0Z, RG_Z_RAW, RG_Z_RAW);
      6'd6:  u = mk(OP_RED, RG_R1X, RG_X_RAW, RG_X_RAW);
      6'd7:  u = mk(OP_RED, RG_R1Z, RG_Z_RAW, RG_Z_RAW);
      6'd8:  u = mk(OP_MUL, RG_S0,  RG_R0X,   RG_R1X);
      6'd9:  u = mk(OP_MUL, RG_S1,  RG_R0Z,   RG_R1Z);
      6'd10: u = mk(OP_MUL, RG_S2,  RG_R0X,   RG_R1Z);
      6'd11: u = mk(OP_MUL, RG_S3,  RG_R0Z,   RG_R1X);
      6'd12: u = mk(OP_MUL, RG_S4,  RG_CA,    RG_S1);
      6'd13: u = mk(OP_SUB, RG_S5,  RG_S0,    RG_S4);
      6'd14: u = mk(OP_MUL, RG_S5,  RG_S5,    RG_S5);
      6'd15: u = mk(OP_MUL, RG_S6,  RG_CB,    RG_S1);
      6'd16: u = mk(OP_ADD, RG_S6,  RG_S6,    RG_S6);
      6'd17: u = mk(OP_ADD, RG_S6,  RG_S6,    RG_S6);
      6'd18: u = mk(OP_ADD, RG_S7,  RG_S2,    RG_S3);
      6'd19: u = mk(OP_MUL, RG_S6,  RG_S6,    RG_S7);
      6'd20: u = mk(OP_SUB, RG_S5,  RG_S5,    RG_S6);
      6'd21: u = mk(OP_SUB, RG_S8,  RG_S2,    RG_S3);
      6'd22: u = mk(OP_MUL, RG_S8,  RG_S8,    RG_S8);
      6'd23: u = mk(OP_MUL, RG_VAX, RG_PZ,    RG_S5);
      6'd24: u = mk(OP_MUL, RG_VAZ, RG_PX,    RG_S8);
      6'd25: u = mk(OP_MUL, RG_S0,  RG_VDX,   RG_VDX);
      6'd26: u = mk(OP_MUL, RG_S1,  RG_VDZ,   RG_VDZ);
      6'd27: u = mk(OP_MUL, RG_S2,  RG_CA,    RG_S1);
      6'd28: u = mk(OP_SUB, RG_S3,  RG_S0,    RG_S2);
      6'd29: u = mk(OP_MUL, RG_S3,  RG_S3,    RG_S3);
      6'd30: u = mk(OP_MUL, RG_S4,  RG_CB,    RG_S1);
      6'd31: u = mk(OP_MUL, RG_S5,  RG_VDX,   RG_VDZ);
      6'd32: u = mk(OP_MUL, RG_S6,  RG_S4,    RG_S5);
      6'd33: u = mk(OP_ADD, RG_S6,  RG_S6,    RG_S6);
      6'd34: u = mk(OP_ADD, RG_S6,  RG_S6,    RG_S6);
      6'd35: u = mk(OP_ADD, RG_S6,  RG_S6,    RG_S6);
      6'd36: u = mk(OP_SUB, RG_VDX, RG_S3,    RG_S6);
      6'd37: u = mk(OP_ADD, RG_S7,  RG_S0,    RG_S2);
      6'd38: u = mk(OP_MUL, RG_S7,  RG_S7,    RG_S5);
      6'd39: u = mk(OP_MUL, RG_S8,  RG_S4,    RG_S1);
      6'd40: u = mk(OP_ADD, RG_S7,  RG_S7,    RG_S8);
      6'd41: u = mk(OP_ADD, RG_S7,  RG_S7,    RG_S7);
      6'd42: u = mk(OP_ADD, RG_VDZ, RG_S7,    RG_S7);
      default: u = mk(OP_ADD, RG_S0, RG_S0, RG_S0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ src/xlsm_ram.sv @@
`default_nettype none

module xlsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/xonly_ladder_scalar_mul.sv @@
// Channel  Handshake              Word fields
// request  req_valid / req_stall  action, limb_index, limb_value
// result   rsp_valid / rsp_stall  coord_select, out_index, out_limb, last
//
// Loads are written into storage as they are accepted. A start scans the scalar for its top set bit,
// then runs every field operation on one shared bit-serial unit: a multiply walks
// the operand bit by bit with a double and a conditional add, after a limb-by-limb fetch and before a
// limb-by-limb write-back; about 20 multiplies per scalar bit.
// rst clears control only; operand and point storage is undefined until loaded.
// req_stall is high for the whole start; a stalled result holds the engine.
`default_nettype none

module xonly_ladder_scalar_mul #(
  parameter int LIMBS     = 4,
  parameter int LIMB_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  action,
  input  wire logic [1:0]  limb_index,
  input  wire logic [63:0] limb_value,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic             coord_select,
  output logic [1:0]       out_index,
  output logic [63:0]      out_limb,
  output logic             last
);

  localparam int TOTAL   = LIMBS * LIMB_BITS;
  localparam int TW      = TOTAL + 1;
  localparam int LIMB_AW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int AW      = xlsm_pkg::REG_AW + LIMB_AW;
  localparam int DEPTH   = 1 << AW;
  localparam int CW      = $clog2(TOTAL + 1);
  localparam int LCW     = $clog2(LIMBS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_STORE = 3'd4;
  localparam logic [2:0] ST_ORD   = 3'd5;
  localparam logic [2:0] ST_OWT   = 3'd6;

  logic [2:0]           state;
  logic [TOTAL-1:0]     modv;
  logic [TOTAL-1:0]     kreg;
  logic [TOTAL-1:0]     ks;
  logic [CW-1:0]        cnt;
  logic                 kbit;
  logic                 zero_res;
  logic [5:0]           pc;
  logic [TOTAL-1:0]     opa;
  logic [TOTAL-1:0]     opb;
  logic [TOTAL-1:0]     acc;
  logic [LCW-1:0]       li;
  logic                 fsel;
  logic [CW-1:0]        bc;
  logic                 ph;
  logic                 osel;
  logic [LIMB_AW-1:0]   opos;

  xlsm_pkg::uop_t         cur;
  logic [xlsm_pkg::REG_AW-1:0] src_reg;
  logic [xlsm_pkg::REG_AW-1:0] dst_reg;
  logic [xlsm_pkg::REG_AW-1:0] load_reg;
  logic                 load_ram;
  logic                 acc_in;
  logic                 idx_ok;
  logic [LIMB_BITS-1:0] val;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [LIMB_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [LIMB_BITS-1:0] ram_rdata;
  logic [TOTAL-1:0]     am_x;
  logic [TOTAL-1:0]     am_y;
  logic                 am_c;
  logic [TOTAL-1:0]     am;
  logic                 rsp_load;

  function automatic logic [TOTAL-1:0] addmod(input logic [TOTAL-1:0] x,
                                              input logic [TOTAL-1:0] y,
                                              input logic cin,
                                              input logic [TOTAL-1:0] p);
    logic [TW-1:0] s;
    logic [TW-1:0] d;
    s = {1'b0, x} + {1'b0, y} + TW'(cin);
    d = s - {1'b0, p};
    return (s >= {1'b0, p}) ? d[TOTAL-1:0] : s[TOTAL-1:0];
  endfunction

  // The sum target and doubled point swap with the current scalar bit.
  function automatic logic [xlsm_pkg::REG_AW-1:0] resolve(
      input logic [xlsm_pkg::REG_AW-1:0] code, input logic b);
    logic [xlsm_pkg::REG_AW-1:0] r;
    unique case (code)
      xlsm_pkg::RG_VAX: r = b ? xlsm_pkg::RG_R0X : xlsm_pkg::RG_R1X;
      xlsm_pkg::RG_VAZ: r = b ? xlsm_pkg::RG_R0Z : xlsm_pkg::RG_R1Z;
      xlsm_pkg::RG_VDX: r = b ? xlsm_pkg::RG_R1X : xlsm_pkg::RG_R0X;
      xlsm_pkg::RG_VDZ: r = b ? xlsm_pkg::RG_R1Z : xlsm_pkg::RG_R0Z;
      default:          r = code;
    endcase
    return r;
  endfunction

  assign req_stall = (state != ST_IDLE);
  assign acc_in    = req_valid && !req_stall;
  assign idx_ok    = (32'(limb_index) < LIMBS);
  assign val       = limb_value[LIMB_BITS-1:0];
  assign cur       = xlsm_pkg::ucode(pc);
  assign src_reg   = resolve(fsel ? cur.sb : cur.sa, kbit);
  assign dst_reg   = resolve(cur.dst, kbit);
  assign rsp_load  = (state == ST_OWT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    load_ram = 1'b1;
    unique case (action)
      xlsm_pkg::ACT_LOAD_A: load_reg = xlsm_pkg::RG_A_RAW;
      xlsm_pkg::ACT_LOAD_B: load_reg = xlsm_pkg::RG_B_RAW;
      xlsm_pkg::ACT_LOAD_X: load_reg = xlsm_pkg::RG_X_RAW;
      xlsm_pkg::ACT_LOAD_Z: load_reg = xlsm_pkg::RG_Z_RAW;
      default: begin
        load_reg = xlsm_pkg::RG_A_RAW;
        load_ram = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state == ST_STORE) begin
      ram_we    = 1'b1;
      ram_waddr = {dst_reg, li[LIMB_AW-1:0]};
      ram_wdata = acc[LIMB_BITS-1:0];
    end else begin
      ram_we    = acc_in && load_ram && idx_ok;
      ram_waddr = {load_reg, LIMB_AW'(limb_index)};
      ram_wdata = val;
    end
  end

  always_comb begin
    if (state == ST_ORD || state == ST_OWT) begin
      ram_raddr = {osel ? xlsm_pkg::RG_R0Z : xlsm_pkg::RG_R0X, opos};
    end else begin
      ram_raddr = {src_reg, li[LIMB_AW-1:0]};
    end
  end

  always_comb begin
    unique case (cur.op)
      xlsm_pkg::OP_MUL: begin
        am_x = acc;
        am_y = ph ? opa : acc;
        am_c = 1'b0;
      end
      xlsm_pkg::OP_RED: begin
        am_x = acc;
        am_y = acc;
        am_c = opb[TOTAL-1];
      end
      default: begin
        am_x = opa;
        am_y = opb;
        am_c = 1'b0;
      end
    endcase
    am = addmod(am_x, am_y, am_c, modv);
  end

  xlsm_ram #(
    .WIDTH (LIMB_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Modulus and scalar live in flops: every step compares against p.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LIMBS; l++) begin
      if (acc_in && 32'(limb_index) == l) begin
        if (action == xlsm_pkg::ACT_LOAD_P) begin
          modv[l*LIMB_BITS +: LIMB_BITS] <= val;
        end
        if (action == xlsm_pkg::ACT_LOAD_K) begin
          kreg[l*LIMB_BITS +: LIMB_BITS] <= val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (acc_in && action == xlsm_pkg::ACT_START) begin
            osel <= 1'b0;
            opos <= '0;
            if (modv == '0 || kreg == '0) begin
              zero_res <= 1'b1;
              state    <= ST_ORD;
            end else begin
              zero_res <= 1'b0;
              ks       <= kreg;
              cnt      <= CW'(TOTAL);
              state    <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          ks  <= ks << 1;
          cnt <= cnt - 1'b1;
          if (ks[TOTAL-1]) begin
            // Top set bit consumed; the initial doubling targets R1.
            pc    <= '0;
            kbit  <= 1'b1;
            li    <= '0;
            fsel  <= 1'b0;
            state <= ST_FETCH;
          end
        end

        ST_FETCH: begin
          if (li != '0) begin
            if (fsel) begin
              opb <= TOTAL'({ram_rdata, opb} >> LIMB_BITS);
            end else begin
              opa <= TOTAL'({ram_rdata, opa} >> LIMB_BITS);
            end
          end
          if (li == LCW'(LIMBS)) begin
            li <= '0;
            if (!fsel) begin
              fsel <= 1'b1;
            end else begin
              acc   <= '0;
              bc    <= '0;
              ph    <= 1'b0;
              state <= ST_EXEC;
            end
          end else begin
            li <= li + 1'b1;
          end
        end

        ST_EXEC: begin
          unique case (cur.op)
            xlsm_pkg::OP_MUL: begin
              if (!ph) begin
                acc <= am;
                ph  <= 1'b1;
              end else begin
                if (opb[TOTAL-1]) begin
                  acc <= am;
                end
                opb <= opb << 1;
                ph  <= 1'b0;
                bc  <= bc + 1'b1;
                if (bc == CW'(TOTAL - 1)) begin
                  li    <= '0;
                  state <= ST_STORE;
                end
              end
            end
            xlsm_pkg::OP_RED: begin
              acc <= am;
              opb <= opb << 1;
              bc  <= bc + 1'b1;
              if (bc == CW'(TOTAL - 1)) begin
                li    <= '0;
                state <= ST_STORE;
              end
            end
            xlsm_pkg::OP_SUB: begin
              if (!ph) begin
                opb <= modv - opb;
                ph  <= 1'b1;
              end else begin
                acc   <= am;
                li    <= '0;
                state <= ST_STORE;
              end
            end
            default: begin
              acc   <= am;
              li    <= '0;
              state <= ST_STORE;
            end
          endcase
        end

        ST_STORE: begin
          acc <= acc >> LIMB_BITS;
          if (li == LCW'(LIMBS - 1)) begin
            li   <= '0;
            fsel <= 1'b0;
            if (pc == xlsm_pkg::PC_INIT_END) begin
              pc    <= xlsm_pkg::PC_DBL_START;
              state <= ST_FETCH;
            end else if (pc == xlsm_pkg::PC_DBL_END) begin
              if (cnt == '0) begin
                state <= ST_ORD;
              end else begin
                kbit  <= ks[TOTAL-1];
                ks    <= ks << 1;
                cnt   <= cnt - 1'b1;
                pc    <= xlsm_pkg::PC_ADD_START;
                state <= ST_FETCH;
              end
            end else begin
              pc    <= pc + 1'b1;
              state <= ST_FETCH;
            end
          end else begin
            li <= li + 1'b1;
          end
        end

        ST_ORD: begin
          state <= ST_OWT;
        end

        ST_OWT: begin
          if (rsp_load) begin
            if (opos == LIMB_AW'(LIMBS - 1)) begin
              opos <= '0;
              osel <= 1'b1;
              state <= osel ? ST_IDLE : ST_ORD;
            end else begin
              opos  <= opos + 1'b1;
              state <= ST_ORD;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      coord_select <= osel;
      out_index    <= 2'(opos);
      out_limb     <= zero_res ? 64'd0 : 64'(ram_rdata);
      last         <= osel && (opos == LIMB_AW'(LIMBS - 1));
    end
  end

endmodule

`default_nettype wire

@@ src/xlsm_checker.sv @@
`default_nettype none
`include "xonly_ladder_scalar_mul_assert.svh"

module xlsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic [2:0]  action,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic        coord_select,
  input wire logic [1:0]  out_index,
  input wire logic [63:0] out_limb,
  input wire logic        last
);

  `XLSM_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(out_limb) && $stable(coord_select) && $stable(out_index) && $stable(last), "stalled result word changed")
  `XLSM_NEXT(a_start_busy, req_valid && !req_stall && action == xlsm_pkg::ACT_START, req_stall, "block not busy after start")
  `XLSM_IMPL(a_last_is_z, rsp_valid && last, coord_select, "last flag on an X word")
  `XLSM_NEXT(a_load_quiet, req_valid && !req_stall && action != xlsm_pkg::ACT_START && !rsp_valid, !rsp_valid, "result word after a load")

endmodule

bind xonly_ladder_scalar_mul xlsm_checker u_xlsm_checker (.*);

`default_nettype wire
